### hw/rtl/idv_pkg.sv
// ----------------------------------------------------------------------------
// idv_pkg: shared types and constants of the ISO date validator
//
// Character codes, line positions, status codes and the record that carries
// one parsed line from the parser to the calendar checker.
// ----------------------------------------------------------------------------
package idv_pkg;

    // Character codes
    localparam logic [7:0] CHAR_DASH = 8'd45;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    // Positions within the line
    localparam logic [3:0] YEAR_CENT_END = 4'd2;
    localparam logic [3:0] DASH_POS_A    = 4'd4;
    localparam logic [3:0] DASH_POS_B    = 4'd7;
    localparam logic [3:0] DATE_LEN      = 4'd10;
    localparam logic [3:0] POS_MAX       = 4'd15;

    // Calendar limits
    localparam logic [6:0] MONTH_FEB     = 7'd2;
    localparam logic [6:0] MONTH_APR     = 7'd4;
    localparam logic [6:0] MONTH_JUN     = 7'd6;
    localparam logic [6:0] MONTH_SEP     = 7'd9;
    localparam logic [6:0] MONTH_NOV     = 7'd11;
    localparam logic [6:0] MONTH_MAX     = 7'd12;
    localparam logic [6:0] DAYS_LONG     = 7'd31;
    localparam logic [6:0] DAYS_SHORT    = 7'd30;
    localparam logic [6:0] DAYS_FEB_LEAP = 7'd29;
    localparam logic [6:0] DAYS_FEB      = 7'd28;

    // Configuration register map
    localparam int unsigned PADDR_W      = 3;
    localparam logic        IDX_MIN_YEAR = 1'b0;
    localparam logic        IDX_MAX_YEAR = 1'b1;
    localparam logic [13:0] MIN_YEAR_RST = 14'd1;
    localparam logic [13:0] MAX_YEAR_RST = 14'd9999;

    // Result status codes
    typedef enum logic [1:0] {
        ST_VALID  = 2'd0,
        ST_FORMAT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // One parsed line on its way to the checker
    typedef struct packed {
        logic        valid;
        logic        fmt_ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  cent;   // first two year digits
        logic [6:0]  yy;     // last two year digits
    } idv_line_t;

endpackage

### hw/rtl/idv_if.sv
// ----------------------------------------------------------------------------
// idv_if: stream channels of the ISO date validator
//
// Character channel into the block and date result channel out of it, each
// with valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface idv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface idv_date_if;
    logic             valid;
    logic             ready;
    idv_pkg::status_t status;
    logic [13:0]      year;
    logic [6:0]       month;
    logic [6:0]       day;

    modport source (output valid, output status, output year, output month,
                    output day, input ready);
    modport sink   (input valid, input status, input year, input month,
                    input day, output ready);
endinterface

### hw/rtl/iso_date_string_validator.sv
// ----------------------------------------------------------------------------
// iso_date_string_validator: YYYY-MM-DD date line checker
//
// Takes a text line one byte per beat and reports, for each line, whether it
// is a valid ISO calendar date within the configured year bounds.
// ----------------------------------------------------------------------------
// The block takes one character beat per clock cycle while it does not stall,
// lines back to back, and gives one result beat per line after the line's
// last character has passed the parser's line register and then the output
// register. A character beat stalls only while both the line register
// and the output register are full and the result sink holds off its ready.
// Each beat is handled by the character parser and each line by the calendar
// checker. The user must write the year bounds min_year (byte address 0) and
// max_year (byte address 4) over the APB port only while no line is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module iso_date_string_validator (
    input  logic                         clk,
    input  logic                         rst_n,
    idv_char_if.sink                     chars,
    idv_date_if.source                   dates,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [idv_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import idv_pkg::*;

    logic [13:0] min_year_reg;
    logic [13:0] max_year_reg;
    logic        cfg_write;
    logic        cfg_index;
    idv_line_t   line;
    logic        line_ready;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= MIN_YEAR_RST;
            max_year_reg <= MAX_YEAR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                IDX_MIN_YEAR: min_year_reg <= pwdata[13:0];
                IDX_MAX_YEAR: max_year_reg <= pwdata[13:0];
                default:      ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (cfg_index)
            IDX_MIN_YEAR: prdata = {18'd0, min_year_reg};
            IDX_MAX_YEAR: prdata = {18'd0, max_year_reg};
            default:      prdata = '0;
        endcase
    end

    // Character parser
    idv_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .line       (line),
        .line_ready (line_ready)
    );

    // Calendar checker and output register
    idv_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .line       (line),
        .line_ready (line_ready),
        .min_year   (min_year_reg),
        .max_year   (max_year_reg),
        .dates      (dates)
    );

endmodule

### hw/rtl/idv_parse.sv
// ----------------------------------------------------------------------------
// idv_parse: character parser of the ISO date validator
//
// Tracks the position in the line, checks each character against the
// YYYY-MM-DD pattern and builds up the digit fields. On the last beat of a
// line it loads a line record for the checker and clears its state.
// ----------------------------------------------------------------------------
module idv_parse (
    input  logic               clk,
    input  logic               rst_n,
    idv_char_if.sink           chars,
    output idv_pkg::idv_line_t line,
    input  logic               line_ready
);
    import idv_pkg::*;

    logic [3:0]  position_reg, position_next;
    logic        format_bad_reg, format_bad_next;
    logic [13:0] year_acc_reg, year_acc_next;
    logic [6:0]  month_acc_reg, month_acc_next;
    logic [6:0]  day_acc_reg, day_acc_next;
    logic [6:0]  cent_acc_reg, cent_acc_next;
    logic [6:0]  yy_acc_reg, yy_acc_next;
    idv_line_t   line_reg;
    logic        accept;
    logic [3:0]  digit;

    // The line record slot frees up when the checker takes it
    assign chars.ready = !line_reg.valid || line_ready;
    assign accept      = chars.valid && chars.ready;
    assign digit       = chars.symbol[3:0];
    assign line        = line_reg;

    // Per-character check and digit accumulation
    always_comb
    begin
        format_bad_next = format_bad_reg;
        year_acc_next   = year_acc_reg;
        month_acc_next  = month_acc_reg;
        day_acc_next    = day_acc_reg;
        cent_acc_next   = cent_acc_reg;
        yy_acc_next     = yy_acc_reg;
        if (position_reg >= DATE_LEN)
        begin
            format_bad_next = 1'b1;
        end
        else if (position_reg == DASH_POS_A || position_reg == DASH_POS_B)
        begin
            if (chars.symbol != CHAR_DASH)
            begin
                format_bad_next = 1'b1;
            end
        end
        else if (chars.symbol < CHAR_ZERO || chars.symbol > CHAR_NINE)
        begin
            format_bad_next = 1'b1;
        end
        else if (position_reg < DASH_POS_A)
        begin
            year_acc_next = year_acc_reg * 14'd10 + {10'd0, digit};
            if (position_reg < YEAR_CENT_END)
            begin
                cent_acc_next = cent_acc_reg * 7'd10 + {3'd0, digit};
            end
            else
            begin
                yy_acc_next = yy_acc_reg * 7'd10 + {3'd0, digit};
            end
        end
        else if (position_reg < DASH_POS_B)
        begin
            month_acc_next = month_acc_reg * 7'd10 + {3'd0, digit};
        end
        else
        begin
            day_acc_next = day_acc_reg * 7'd10 + {3'd0, digit};
        end
        position_next = (position_reg != POS_MAX) ? position_reg + 4'd1 : position_reg;
    end

    // Line state: cleared after the last beat of each line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            format_bad_reg <= 1'b0;
            year_acc_reg   <= '0;
            month_acc_reg  <= '0;
            day_acc_reg    <= '0;
            cent_acc_reg   <= '0;
            yy_acc_reg     <= '0;
        end
        else if (accept)
        begin
            if (chars.last)
            begin
                position_reg   <= '0;
                format_bad_reg <= 1'b0;
                year_acc_reg   <= '0;
                month_acc_reg  <= '0;
                day_acc_reg    <= '0;
                cent_acc_reg   <= '0;
                yy_acc_reg     <= '0;
            end
            else
            begin
                position_reg   <= position_next;
                format_bad_reg <= format_bad_next;
                year_acc_reg   <= year_acc_next;
                month_acc_reg  <= month_acc_next;
                day_acc_reg    <= day_acc_next;
                cent_acc_reg   <= cent_acc_next;
                yy_acc_reg     <= yy_acc_next;
            end
        end
    end

    // Line record handed to the checker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
        end
        else if (accept && chars.last)
        begin
            line_reg.valid  <= 1'b1;
            line_reg.fmt_ok <= !format_bad_next && (position_next == DATE_LEN);
            line_reg.year   <= year_acc_next;
            line_reg.month  <= month_acc_next;
            line_reg.day    <= day_acc_next;
            line_reg.cent   <= cent_acc_next;
            line_reg.yy     <= yy_acc_next;
        end
        else if (line_ready)
        begin
            line_reg.valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    // A line always starts from position zero after its last beat
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && chars.last |=> position_reg == '0 && !format_bad_reg)
        else $error("line state not cleared after last beat");

    // A line record only appears after the last beat of a line
    a_line_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(line_reg.valid) |-> $past(accept && chars.last))
        else $error("line record without a last beat");
`endif

endmodule

### hw/rtl/idv_check.sv
// ----------------------------------------------------------------------------
// idv_check: calendar checker of the ISO date validator
//
// Checks a parsed line against the year bounds and the calendar, and holds
// the result in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module idv_check (
    input  logic               clk,
    input  logic               rst_n,
    input  idv_pkg::idv_line_t line,
    output logic               line_ready,
    input  logic [13:0]        min_year,
    input  logic [13:0]        max_year,
    idv_date_if.source         dates
);
    import idv_pkg::*;

    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [13:0] year_reg;
    logic [6:0]  month_reg;
    logic [6:0]  day_reg;
    logic        year_ok;
    logic        month_ok;
    logic        leap;
    logic [6:0]  month_days;
    logic        day_ok;
    logic        load;

    // Output register frees up when the sink takes its beat
    assign line_ready = !out_valid_reg || dates.ready;
    assign load       = line.valid && line_ready;

    // Gregorian leap year from the two digit pairs of the year
    assign leap = (line.yy[1:0] == 2'd0) && (line.yy != 7'd0 || line.cent[1:0] == 2'd0);

    // Year bounds and month range
    assign year_ok  = (line.year >= min_year) && (line.year <= max_year);
    assign month_ok = (line.month != 7'd0) && (line.month <= MONTH_MAX);

    // Length of the month
    always_comb
    begin
        case (line.month) inside
            MONTH_FEB:
                month_days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:
                month_days = DAYS_SHORT;
            default:
                month_days = DAYS_LONG;
        endcase
    end

    assign day_ok = (line.day != 7'd0) && (line.day <= month_days);

    // Result status
    always_comb
    begin
        if (!line.fmt_ok)
        begin
            status_next = ST_FORMAT;
        end
        else if (year_ok && month_ok && day_ok)
        begin
            status_next = ST_VALID;
        end
        else
        begin
            status_next = ST_RANGE;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (line_ready)
        begin
            out_valid_reg <= line.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            year_reg   <= line.fmt_ok ? line.year  : 14'd0;
            month_reg  <= line.fmt_ok ? line.month : 7'd0;
            day_reg    <= line.fmt_ok ? line.day   : 7'd0;
        end
    end

    assign dates.valid  = out_valid_reg;
    assign dates.status = status_reg;
    assign dates.year   = year_reg;
    assign dates.month  = month_reg;
    assign dates.day    = day_reg;

`ifndef SYNTHESIS
    // A badly formatted line reports zero date fields
    a_format_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dates.valid && dates.status == ST_FORMAT |->
            dates.year == 14'd0 && dates.month == 7'd0 && dates.day == 7'd0)
        else $error("format error with nonzero date fields");

    // A valid date lies within the calendar and the year bounds
    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        dates.valid && dates.status == ST_VALID |->
            dates.month != 7'd0 && dates.month <= MONTH_MAX &&
            dates.day != 7'd0 && dates.day <= DAYS_LONG &&
            dates.year >= min_year && dates.year <= max_year)
        else $error("valid status on an impossible date");
`endif

endmodule
